>>> rtl/core/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Widths, scale constants, reciprocals and sector codes for the HSV to RGB
// pixel pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int HUE_W  = 15;
  localparam int BYTE_W = 8;
  localparam int REM_W  = 12;
  localparam int SEC_W  = 4;
  localparam int PROD_W = 20;
  localparam int TOP_W  = 28;
  localparam int PIX_W  = 32;

  localparam int unsigned SECTOR_SPAN = 3840;
  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned FRAC_DEN    = FULL_SCALE * SECTOR_SPAN;
  localparam int unsigned NUM_SECT_TH = 8;

  // x / 255 for x < 2**16: (x * P_RECIP) >> P_SHIFT
  localparam int unsigned P_RECIP_W = 17;
  localparam int unsigned P_RECIP   = 65794;
  localparam int unsigned P_SHIFT   = 24;

  // y / 3825 for y < 2**20: (y * Q_RECIP) >> Q_SHIFT
  localparam int unsigned Q_RECIP_W = 21;
  localparam int unsigned Q_RECIP   = 1122868;
  localparam int unsigned Q_SHIFT   = 32;
  localparam int unsigned Q_PRE_SH  = 8;

  localparam logic [BYTE_W-1:0] ALPHA_FULL = 8'hFF;

  typedef logic [SEC_W-1:0] sector_t;

  localparam sector_t SEC_RED_YEL = 4'd0;
  localparam sector_t SEC_YEL_GRN = 4'd1;
  localparam sector_t SEC_GRN_CYN = 4'd2;
  localparam sector_t SEC_CYN_BLU = 4'd3;
  localparam sector_t SEC_BLU_MAG = 4'd4;

endpackage

>>> rtl/core/hsv_if.sv
// ----------------------------------------------------------------------------
// hsv_if
// Valid/ready channels: HSV pixel words in, packed ABGR words out.
// ----------------------------------------------------------------------------
interface hsv_pix_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

interface hsv_rgb_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_color;

  modport source (output valid, output packed_color, input ready);
  modport sink   (input valid, input packed_color, output ready);
endinterface

>>> rtl/core/hsv_to_rgb_pixel_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// HSV to packed ABGR conversion, six register stages.
// ----------------------------------------------------------------------------
// Takes one HSV word per clock and returns one packed ABGR word per clock
// unless a stalled output word holds the pipeline. The six register stages
// are sector split, products, difference and p scaling, value scaling, q/t
// reciprocal scaling and channel select. The whole pipeline advances together:
// it moves whenever the output register is empty or its word is taken, so
// in_hsv.ready follows out_rgb.ready combinationally. Alpha is always 0xFF.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_unit
  import hsv_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  hsv_pix_if.sink        in_hsv,
  hsv_rgb_if.source      out_rgb
);

  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1
  sector_t             s1_sec_r, s1_sec_nxt;
  logic [REM_W-1:0]    s1_rem_r, s1_rem_nxt;
  logic [BYTE_W-1:0]   s1_sat_r, s1_val_r;

  // stage 2
  sector_t             s2_sec_r;
  logic [BYTE_W-1:0]   s2_sat_r, s2_val_r;
  logic [PROD_W-1:0]   s2_sq_r, s2_sq_nxt;
  logic [15:0]         s2_pv_r, s2_pv_nxt;

  // stage 3
  sector_t             s3_sec_r;
  logic [BYTE_W-1:0]   s3_val_r, s3_p_r, s3_p_nxt;
  logic [PROD_W-1:0]   s3_dq_r, s3_dq_nxt, s3_dt_r, s3_dt_nxt;
  logic [32:0]         p_prod;

  // stage 4
  sector_t             s4_sec_r;
  logic [BYTE_W-1:0]   s4_val_r, s4_p_r;
  logic [TOP_W-1:0]    s4_tq_r, s4_tq_nxt, s4_tt_r, s4_tt_nxt;

  // stage 5
  sector_t             s5_sec_r;
  logic [BYTE_W-1:0]   s5_val_r, s5_p_r, s5_q_r, s5_q_nxt, s5_t_r, s5_t_nxt;
  logic [40:0]         q_prod, t_prod;

  // stage 6
  logic [PIX_W-1:0]    s6_pix_r, s6_pix_nxt;
  logic [BYTE_W-1:0]   red, grn, blu;

  assign adv          = !v6_r || out_rgb.ready;
  assign in_hsv.ready = adv;
  assign out_rgb.valid        = v6_r;
  assign out_rgb.packed_color = s6_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_hsv.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // split hue into sector and remainder
  always_comb begin
    s1_sec_nxt = '0;
    for (int k = 1; k <= NUM_SECT_TH; k++) begin
      s1_sec_nxt = s1_sec_nxt +
                   SEC_W'(in_hsv.hue >= HUE_W'(k * SECTOR_SPAN));
    end
    s1_rem_nxt = REM_W'(in_hsv.hue - HUE_W'(s1_sec_nxt * HUE_W'(SECTOR_SPAN)));
  end

  assign s2_sq_nxt = PROD_W'(s1_sat_r) * PROD_W'(s1_rem_r);
  assign s2_pv_nxt = 16'(BYTE_W'(FULL_SCALE) - s1_sat_r) * 16'(s1_val_r);

  // t uses s*(3840-r) = s*3840 - s*r
  assign s3_dq_nxt = PROD_W'(FRAC_DEN) - s2_sq_r;
  assign s3_dt_nxt = PROD_W'(FRAC_DEN) - PROD_W'(s2_sat_r) * PROD_W'(SECTOR_SPAN) + s2_sq_r;
  assign p_prod    = 33'(s2_pv_r) * 33'(P_RECIP);
  assign s3_p_nxt  = p_prod[P_SHIFT +: BYTE_W];

  assign s4_tq_nxt = TOP_W'(s3_val_r) * TOP_W'(s3_dq_r);
  assign s4_tt_nxt = TOP_W'(s3_val_r) * TOP_W'(s3_dt_r);

  // drop the factor 256 of the denominator, then divide by 3825
  assign q_prod   = 41'(s4_tq_r[TOP_W-1:Q_PRE_SH]) * 41'(Q_RECIP);
  assign t_prod   = 41'(s4_tt_r[TOP_W-1:Q_PRE_SH]) * 41'(Q_RECIP);
  assign s5_q_nxt = q_prod[Q_SHIFT +: BYTE_W];
  assign s5_t_nxt = t_prod[Q_SHIFT +: BYTE_W];

  always_comb begin
    case (s5_sec_r)
      SEC_RED_YEL: begin red = s5_val_r; grn = s5_t_r;   blu = s5_p_r;   end
      SEC_YEL_GRN: begin red = s5_q_r;   grn = s5_val_r; blu = s5_p_r;   end
      SEC_GRN_CYN: begin red = s5_p_r;   grn = s5_val_r; blu = s5_t_r;   end
      SEC_CYN_BLU: begin red = s5_p_r;   grn = s5_q_r;   blu = s5_val_r; end
      SEC_BLU_MAG: begin red = s5_t_r;   grn = s5_p_r;   blu = s5_val_r; end
      default:     begin red = s5_val_r; grn = s5_p_r;   blu = s5_q_r;   end
    endcase
    s6_pix_nxt = {ALPHA_FULL, blu, grn, red};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sec_r <= s1_sec_nxt;
      s1_rem_r <= s1_rem_nxt;
      s1_sat_r <= in_hsv.saturation;
      s1_val_r <= in_hsv.value;

      s2_sec_r <= s1_sec_r;
      s2_sat_r <= s1_sat_r;
      s2_val_r <= s1_val_r;
      s2_sq_r  <= s2_sq_nxt;
      s2_pv_r  <= s2_pv_nxt;

      s3_sec_r <= s2_sec_r;
      s3_val_r <= s2_val_r;
      s3_dq_r  <= s3_dq_nxt;
      s3_dt_r  <= s3_dt_nxt;
      s3_p_r   <= s3_p_nxt;

      s4_sec_r <= s3_sec_r;
      s4_val_r <= s3_val_r;
      s4_p_r   <= s3_p_r;
      s4_tq_r  <= s4_tq_nxt;
      s4_tt_r  <= s4_tt_nxt;

      s5_sec_r <= s4_sec_r;
      s5_val_r <= s4_val_r;
      s5_p_r   <= s4_p_r;
      s5_q_r   <= s5_q_nxt;
      s5_t_r   <= s5_t_nxt;

      s6_pix_r <= s6_pix_nxt;
    end
  end

endmodule

>>> rtl/core/hsv_chk.sv
// ----------------------------------------------------------------------------
// hsv_chk
// Port-level checks for hsv_to_rgb_pixel_unit, attached by bind.
// ----------------------------------------------------------------------------
module hsv_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_color
);

  a_out_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color[31:24] == 8'hFF))
    else $error("alpha byte not 0xFF");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output drain");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_color)))
    else $error("stalled output word changed or dropped");

endmodule

bind hsv_to_rgb_pixel_unit hsv_chk u_hsv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_hsv.ready),
  .out_valid (out_rgb.valid),
  .out_ready (out_rgb.ready),
  .out_color (out_rgb.packed_color)
);

>>> verif/tb_hsv_to_rgb_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel_unit
// Self-checking bench for the HSV to packed ABGR pixel pipeline.
// ----------------------------------------------------------------------------
// Drives HSV words through the valid/ready input channel and checks every
// packed ABGR word against an integer predictor or, for part of the directed
// table, a fixed color. A directed table covers grey, zero value, every
// sector boundary, hue at and past 360 degrees and the field extremes. A
// random stream follows. Both sides idle at random, and the output holds off
// once for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel_unit;
  import hsv_pkg::*;

  localparam int N_RANDOM    = 1700;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 500;
  localparam int DRAIN_CYC   = 24;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [HUE_W-1:0]  hue;
    logic [BYTE_W-1:0] sat;
    logic [BYTE_W-1:0] val;
    bit                typed;
    logic [PIX_W-1:0]  color;
  } hsv_row_t;

  logic clk;
  logic rst_n;

  hsv_pix_if hsv_in_bus ();
  hsv_rgb_if rgb_out_bus ();

  hsv_to_rgb_pixel_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_hsv  (hsv_in_bus),
    .out_rgb (rgb_out_bus)
  );

  logic [PIX_W-1:0] pending_colors[$];
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned taken_cnt;
  int unsigned grey_cnt;
  int unsigned wrap_cnt;
  int unsigned cycle_cnt;
  bit [8:0]    sectors_hit;
  bit          long_hold_done;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [PIX_W-1:0] predict_abgr(logic [HUE_W-1:0] hue,
                                                    logic [BYTE_W-1:0] sat,
                                                    logic [BYTE_W-1:0] val);
    longint unsigned h, s, v, rem, den, p, q, t;
    sector_t sector;
    logic [BYTE_W-1:0] r, g, b;
    h = hue;
    s = sat;
    v = val;
    den = longint'(FULL_SCALE) * longint'(SECTOR_SPAN);
    rem = h % SECTOR_SPAN;
    sector = sector_t'(h / SECTOR_SPAN);
    p = (v * (FULL_SCALE - s)) / FULL_SCALE;
    q = (v * (den - s * rem)) / den;
    t = (v * (den - s * (SECTOR_SPAN - rem))) / den;
    if (s == 0) begin
      r = val;
      g = val;
      b = val;
    end else begin
      case (sector)
        SEC_RED_YEL: begin r = val;    g = t[7:0]; b = p[7:0]; end
        SEC_YEL_GRN: begin r = q[7:0]; g = val;    b = p[7:0]; end
        SEC_GRN_CYN: begin r = p[7:0]; g = val;    b = t[7:0]; end
        SEC_CYN_BLU: begin r = p[7:0]; g = q[7:0]; b = val;    end
        SEC_BLU_MAG: begin r = t[7:0]; g = p[7:0]; b = val;    end
        default:     begin r = val;    g = p[7:0]; b = q[7:0]; end
      endcase
    end
    return {ALPHA_FULL, b, g, r};
  endfunction

  // offer one word, hold it until taken, then queue its expected color
  task automatic send_hsv(logic [HUE_W-1:0] hue, logic [BYTE_W-1:0] sat,
                          logic [BYTE_W-1:0] val, logic [PIX_W-1:0] color,
                          bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      @(negedge clk);
      hsv_in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    hsv_in_bus.valid      <= 1'b1;
    hsv_in_bus.hue        <= hue;
    hsv_in_bus.saturation <= sat;
    hsv_in_bus.value      <= val;
    do @(posedge clk); while (!hsv_in_bus.ready);
    pending_colors.push_back(color);
    sent_cnt++;
    if (sat == 0) grey_cnt++;
    if (hue >= HUE_W'(6 * SECTOR_SPAN)) wrap_cnt++;
    sectors_hit[hue / SECTOR_SPAN] = 1'b1;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int sel;
    int h;
    sel = $urandom_range(0, 19);
    if (sel < 2) return HUE_W'($urandom_range(6 * SECTOR_SPAN + 1, 32767));
    if (sel == 2) begin
      h = int'(SECTOR_SPAN) * $urandom_range(0, 8) + $urandom_range(0, 2) - 1;
      if (h < 0) h = 0;
      return HUE_W'(h);
    end
    return HUE_W'($urandom_range(0, 6 * SECTOR_SPAN));
  endfunction

  // stimulus, drain and verdict
  initial begin
    hsv_row_t rows[];
    logic [HUE_W-1:0]  hue;
    logic [BYTE_W-1:0] sat, val;
    fail_cnt = 0;
    sent_cnt = 0;
    grey_cnt = 0;
    wrap_cnt = 0;
    sectors_hit = '0;
    rst_n = 1'b0;
    hsv_in_bus.valid      = 1'b0;
    hsv_in_bus.hue        = '0;
    hsv_in_bus.saturation = '0;
    hsv_in_bus.value      = '0;
    rows = '{
      '{15'd0,     8'd0,   8'd0,   1'b1, 32'hFF000000},
      '{15'd0,     8'd0,   8'd255, 1'b1, 32'hFFFFFFFF},
      '{15'd23040, 8'd0,   8'd128, 1'b1, 32'hFF808080},
      '{15'd32767, 8'd0,   8'd85,  1'b1, 32'hFF555555},
      '{15'd0,     8'd255, 8'd255, 1'b1, 32'hFF0000FF},
      '{15'd3840,  8'd255, 8'd255, 1'b1, 32'hFF00FFFF},
      '{15'd7680,  8'd255, 8'd255, 1'b1, 32'hFF00FF00},
      '{15'd11520, 8'd255, 8'd255, 1'b1, 32'hFFFFFF00},
      '{15'd15360, 8'd255, 8'd255, 1'b1, 32'hFFFF0000},
      '{15'd19200, 8'd255, 8'd255, 1'b1, 32'hFFFF00FF},
      '{15'd23040, 8'd255, 8'd255, 1'b1, 32'hFFFF00FF},
      '{15'd12345, 8'd255, 8'd0,   1'b1, 32'hFF000000},
      '{15'd3839,  8'd255, 8'd255, 1'b0, '0},
      '{15'd1920,  8'd128, 8'd200, 1'b0, '0},
      '{15'd23039, 8'd255, 8'd255, 1'b0, '0},
      '{15'd23041, 8'd200, 8'd180, 1'b0, '0},
      '{15'd26880, 8'd255, 8'd255, 1'b0, '0},
      '{15'd32767, 8'd255, 8'd255, 1'b0, '0},
      '{15'd30720, 8'd1,   8'd254, 1'b0, '0},
      '{15'd5760,  8'd1,   8'd1,   1'b0, '0},
      '{15'd17000, 8'd170, 8'd85,  1'b0, '0},
      '{15'd9000,  8'd254, 8'd255, 1'b0, '0}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_hsv(rows[i].hue, rows[i].sat, rows[i].val,
               rows[i].typed ? rows[i].color
                             : predict_abgr(rows[i].hue, rows[i].sat, rows[i].val),
               1'b1);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      hue = pick_hue();
      sat = pick_byte();
      val = pick_byte();
      send_hsv(hue, sat, val, predict_abgr(hue, sat, val), ((i / 150) % 3) != 1);
    end

    @(negedge clk);
    hsv_in_bus.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d words converted: %0d grey, %0d at or past 360 degrees, sectors hit %b",
             sent_cnt, grey_cnt, wrap_cnt, sectors_hit);
    $display("output held off %0d cycles once while input kept offering, %0d words checked",
             LONG_HOLD, taken_cnt);
    if (fail_cnt == 0) begin
      $display("PASS hsv_to_rgb_pixel_unit");
    end else begin
      $display("FAIL hsv_to_rgb_pixel_unit");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off
  initial begin
    int stall;
    long_hold_done = 1'b0;
    rgb_out_bus.ready = 1'b1;
    forever begin
      if (!long_hold_done && taken_cnt >= HOLD_AT) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (((taken_cnt / 200) % 3) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall != 0) begin
        @(negedge clk);
        rgb_out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        rgb_out_bus.ready <= 1'b1;
      end
      do @(posedge clk); while (!(rst_n && rgb_out_bus.valid));
    end
  end

  // check each taken word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && rgb_out_bus.valid && rgb_out_bus.ready) begin
      taken_cnt <= taken_cnt + 1;
      if (pending_colors.size() == 0) begin
        $error("packed_color: word with none expected, actual %h", rgb_out_bus.packed_color);
        fail_cnt <= fail_cnt + 1;
      end else if (pending_colors[0] !== rgb_out_bus.packed_color) begin
        $error("packed_color: expected %h actual %h", pending_colors[0],
               rgb_out_bus.packed_color);
        fail_cnt <= fail_cnt + 1;
        void'(pending_colors.pop_front());
      end else begin
        void'(pending_colors.pop_front());
      end
    end
  end

  initial taken_cnt = 0;

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL hsv_to_rgb_pixel_unit");
      $finish;
    end
  end

endmodule
